FILE: rtl/core/ffr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffr_pkg;

  // Verdict codes carried in the low bits of each result beat.
  typedef enum logic [2:0] {
    V_STORED    = 3'd0,
    V_COMPLETE  = 3'd1,
    V_INVALID   = 3'd2,
    V_STALE     = 3'd3,
    V_DUPLICATE = 3'd4,
    V_OFFSET    = 3'd5,
    V_TOO_MANY  = 3'd6
  } verdict_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIM = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 272;
  localparam int unsigned OUT_DATA_W = 152;
  localparam int unsigned DIM_W      = 13;

  // Configuration reset values.
  localparam logic [31:0]      MAGIC_RST      = 32'd0;
  localparam logic [15:0]      STRIDE_RST     = 16'd1400;
  localparam logic [7:0]       HDR_BYTES_RST  = 8'd36;
  localparam logic [DIM_W-1:0] WIDTH_LIM_RST  = 13'd7680;
  localparam logic [DIM_W-1:0] HEIGHT_LIM_RST = 13'd4320;

  // Generation tag kept per seen-bitmap entry. Tag zero means "never seen".
  localparam int unsigned EPOCH_W = 12;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] stride;
    logic [7:0]  hdr_bytes;
    logic [DIM_W-1:0] width_lim;
    logic [DIM_W-1:0] height_lim;
  } cfg_t;

  // Header after the stateless checks, as held in the input register.
  typedef struct packed {
    logic             bad;
    logic             too_many;
    logic [31:0]      frame_id;
    logic [31:0]      frag_index;
    logic [31:0]      frag_total;
    logic [31:0]      frame_bytes;
    logic [15:0]      frag_bytes;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      offset;
    logic [32:0]      end_byte;
  } hdr_t;

endpackage

`default_nettype wire

FILE: rtl/core/ffr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/ffr_hdr_check.sv
`timescale 1ns / 1ps
`default_nettype none

module ffr_hdr_check #(
  parameter int unsigned MAX_FRAGMENTS = 1024,
  parameter int unsigned IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1
) (
  input  wire logic [ffr_pkg::IN_DATA_W-1:0] in_data,
  input  wire ffr_pkg::cfg_t                 cfg,
  output ffr_pkg::hdr_t                      hdr
);
  import ffr_pkg::*;

  logic [15:0]         plen;
  logic [31:0]         magic_word;
  logic [31:0]         frag_index;
  logic [31:0]         frag_total;
  logic [31:0]         frame_bytes;
  logic [31:0]         frag_bytes;
  logic [31:0]         pixel_width;
  logic [31:0]         pixel_height;
  logic [32:0]         expect_len;
  logic [IDX_W+15:0]   product;
  logic                bad;

  assign plen         = in_data[15:0];
  assign magic_word   = in_data[47:16];
  assign frag_index   = in_data[111:80];
  assign frag_total   = in_data[143:112];
  assign frame_bytes  = in_data[175:144];
  assign frag_bytes   = in_data[207:176];
  assign pixel_width  = in_data[239:208];
  assign pixel_height = in_data[271:240];

  assign expect_len = 33'(cfg.hdr_bytes) + 33'(frag_bytes);

  always_comb begin
    bad = 1'b0;
    if (plen < 16'(cfg.hdr_bytes))                              bad = 1'b1;
    if (magic_word != cfg.magic)                                bad = 1'b1;
    if (frag_total == 32'd0 || frag_index >= frag_total)        bad = 1'b1;
    if (frame_bytes == 32'd0 || frag_bytes == 32'd0)            bad = 1'b1;
    if (frag_bytes > 32'(cfg.stride))                           bad = 1'b1;
    if (pixel_width == 32'd0 || pixel_height == 32'd0)          bad = 1'b1;
    if (pixel_width > 32'(cfg.width_lim))                       bad = 1'b1;
    if (pixel_height > 32'(cfg.height_lim))                     bad = 1'b1;
    if (33'(plen) != expect_len)                                bad = 1'b1;
  end

  // Only the low index bits matter once the total is known to fit the bitmap.
  assign product = (IDX_W + 16)'(frag_index[IDX_W-1:0]) * (IDX_W + 16)'(cfg.stride);

  always_comb begin
    hdr.bad         = bad;
    hdr.too_many    = {1'b0, frag_total} > 33'(MAX_FRAGMENTS);
    hdr.frame_id    = in_data[79:48];
    hdr.frag_index  = frag_index;
    hdr.frag_total  = frag_total;
    hdr.frame_bytes = frame_bytes;
    hdr.frag_bytes  = frag_bytes[15:0];
    hdr.width       = pixel_width[DIM_W-1:0];
    hdr.height      = pixel_height[DIM_W-1:0];
    hdr.offset      = 32'(product);
    hdr.end_byte    = 33'(product) + 33'(frag_bytes[15:0]);
  end

endmodule

`default_nettype wire

FILE: rtl/core/frame_fragment_reassembly.sv
`timescale 1ns / 1ps
`default_nettype none

// Fragment reassembly controller. One beat on the in_ channel carries one
// parsed fragment header; for each one the out_ channel returns exactly one
// verdict beat with the payload placement, frame events and running counters.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
//
// The input register holds an accepted header while it is judged against the
// pending-frame state and the seen-bitmap; the verdict then lands in the
// output register, which drives out_tvalid. One header per cycle is
// sustained while out_tready stays high and no clearing pass runs; the seen
// bitmap RAM read is issued at acceptance and a one-deep forward covers a
// write by the preceding header.
//
// The seen-bitmap is a MAX_FRAGMENTS deep RAM of generation tags; starting a
// frame just bumps the generation. After reset, and whenever the 12-bit
// generation wraps (once every 4095 frame starts), a clearing pass over all
// MAX_FRAGMENTS entries runs with in_tready low. When out_tready is low the
// output register holds, one more header may wait in the input register, and
// in_tready then drops until the output beat is taken.
module frame_fragment_reassembly #(
  parameter int unsigned MAX_FRAGMENTS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // [15:0] packet_length, [47:16] magic_word, [79:48] frame_id,
  // [111:80] frag_index, [143:112] frag_total, [175:144] frame_bytes,
  // [207:176] frag_bytes, [239:208] pixel_width, [271:240] pixel_height
  input  wire logic [ffr_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [2:0] verdict, [34:3] write_offset, [50:35] write_length,
  // [51] resolution_changed, [52] frame_started, [84:53] completed_size,
  // [116:85] dropped_total, [148:117] completed_total, [149] stream_seen,
  // [151:150] zero
  output logic [ffr_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [ffr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ffr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ffr_pkg::*;

  localparam int unsigned IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAGMENTS + 1);
  localparam logic [IDX_W-1:0]   LAST_ADDR = IDX_W'(MAX_FRAGMENTS - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic      <= MAGIC_RST;
      cfg_r.stride     <= STRIDE_RST;
      cfg_r.hdr_bytes  <= HDR_BYTES_RST;
      cfg_r.width_lim  <= WIDTH_LIM_RST;
      cfg_r.height_lim <= HEIGHT_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC:      cfg_r.magic      <= cfg_wdata;
        CFG_STRIDE:     cfg_r.stride     <= cfg_wdata[15:0];
        CFG_HDR_BYTES:  cfg_r.hdr_bytes  <= cfg_wdata[7:0];
        CFG_WIDTH_LIM:  cfg_r.width_lim  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT_LIM: cfg_r.height_lim <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stateless header checks feed the input register.
  hdr_t hdr_in;
  hdr_t s1_r;
  logic s1_v_r;

  ffr_hdr_check #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_check (
    .in_data(in_tdata),
    .cfg    (cfg_r),
    .hdr    (hdr_in)
  );

  // Pending-frame state.
  logic              pact_r;
  logic [31:0]       pid_r;
  logic [31:0]       psize_r;
  logic [CNT_W-1:0]  ptot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [31:0]       last_done_r;
  logic              have_done_r;
  logic [DIM_W-1:0]  cur_w_r;
  logic [DIM_W-1:0]  cur_h_r;
  logic [31:0]       drop_r;
  logic [31:0]       done_r;

  // Seen-bitmap tags and clearing pass.
  logic [EPOCH_W-1:0] epoch_r;
  logic               busy_r;
  logic [IDX_W-1:0]   pass_cnt_r;
  logic               keep_v_r;
  logic [IDX_W-1:0]   keep_addr_r;
  logic               fwd_v_r;
  logic [IDX_W-1:0]   fwd_addr_r;
  logic [EPOCH_W-1:0] tag_rd;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [EPOCH_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;

  // Output register.
  logic                  out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Decision signals.
  logic               s1_fire;
  logic               ok;
  logic               res_chg;
  logic               pact_e;
  logic               have_done_e;
  logic               stale;
  logic               start;
  logic               drop_inc;
  logic               clear_now;
  logic               wrap;
  logic [IDX_W-1:0]   idx;
  logic               seen;
  logic               dup;
  logic [31:0]        size_e;
  logic [CNT_W-1:0]   tot_e;
  logic [CNT_W-1:0]   cnt_e;
  logic [CNT_W-1:0]   cnt_inc;
  logic               incons;
  logic               store;
  logic               complete;
  verdict_t           verdict;
  logic [EPOCH_W-1:0] epoch_nxt;
  logic [DIM_W-1:0]   cur_w_nxt;
  logic [DIM_W-1:0]   cur_h_nxt;
  logic [31:0]        drop_nxt;
  logic [31:0]        done_nxt;

  assign s1_fire   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !busy_r && (!s1_v_r || s1_fire) && !(s1_fire && wrap);
  assign idx       = s1_r.frag_index[IDX_W-1:0];

  always_comb begin
    ok          = !s1_r.bad && !s1_r.too_many;
    res_chg     = (s1_r.width != cur_w_r) || (s1_r.height != cur_h_r);
    pact_e      = pact_r && !res_chg;
    have_done_e = have_done_r && !res_chg;
    stale       = (have_done_e && s1_r.frame_id <= last_done_r) ||
                  (pact_e && s1_r.frame_id < pid_r);
    start       = !stale && (!pact_e || s1_r.frame_id != pid_r);
    drop_inc    = ok && start && pact_e && (cnt_r < ptot_r);
    clear_now   = ok && (res_chg || start);
    wrap        = s1_v_r && clear_now && (epoch_r == EPOCH_MAX);
    if (clear_now) begin
      epoch_nxt = wrap ? EPOCH_ONE : epoch_r + EPOCH_ONE;
    end else begin
      epoch_nxt = epoch_r;
    end
    // A write by the header just before this one is not yet in the read data.
    seen      = (tag_rd == epoch_r) || (fwd_v_r && fwd_addr_r == idx);
    dup       = !clear_now && seen;
    size_e    = start ? s1_r.frame_bytes : psize_r;
    tot_e     = start ? CNT_W'(s1_r.frag_total) : ptot_r;
    cnt_e     = start ? '0 : cnt_r;
    cnt_inc   = cnt_e + CNT_W'(1);
    incons    = s1_r.end_byte > {1'b0, size_e};
    store     = ok && !stale && !dup && !incons;
    complete  = store && (cnt_inc >= tot_e);

    if (s1_r.bad) begin
      verdict = V_INVALID;
    end else if (s1_r.too_many) begin
      verdict = V_TOO_MANY;
    end else if (stale) begin
      verdict = V_STALE;
    end else if (dup) begin
      verdict = V_DUPLICATE;
    end else if (incons) begin
      verdict = V_OFFSET;
    end else if (complete) begin
      verdict = V_COMPLETE;
    end else begin
      verdict = V_STORED;
    end

    cur_w_nxt = (ok && res_chg) ? s1_r.width : cur_w_r;
    cur_h_nxt = (ok && res_chg) ? s1_r.height : cur_h_r;
    drop_nxt  = drop_r + 32'(drop_inc);
    done_nxt  = done_r + 32'(complete);
  end

  // Bitmap RAM: the clearing pass owns the write port while it runs.
  always_comb begin
    if (busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = pass_cnt_r;
      ram_wdata = (keep_v_r && keep_addr_r == pass_cnt_r) ? epoch_r : '0;
    end else begin
      ram_we    = s1_fire && store;
      ram_waddr = idx;
      ram_wdata = epoch_nxt;
    end
    ram_raddr = in_tready ? in_tdata[IDX_W+79:80] : idx;
  end

  ffr_ram #(
    .WIDTH(EPOCH_W),
    .DEPTH(MAX_FRAGMENTS)
  ) u_seen_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(tag_rd)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= hdr_in;
    end
  end

  // Frame state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pact_r      <= 1'b0;
      pid_r       <= '0;
      psize_r     <= '0;
      ptot_r      <= '0;
      cnt_r       <= '0;
      last_done_r <= '0;
      have_done_r <= 1'b0;
      cur_w_r     <= '0;
      cur_h_r     <= '0;
      drop_r      <= '0;
      done_r      <= '0;
      epoch_r     <= EPOCH_ONE;
      fwd_v_r     <= 1'b0;
    end else begin
      fwd_v_r <= s1_fire && store;
      if (s1_fire && ok) begin
        cur_w_r <= cur_w_nxt;
        cur_h_r <= cur_h_nxt;
        drop_r  <= drop_nxt;
        done_r  <= done_nxt;
        epoch_r <= epoch_nxt;
        if (start) begin
          pid_r   <= s1_r.frame_id;
          psize_r <= s1_r.frame_bytes;
          ptot_r  <= tot_e;
        end
        if (store) begin
          cnt_r <= cnt_inc;
        end else begin
          cnt_r <= cnt_e;
        end
        if (complete) begin
          pact_r      <= 1'b0;
          have_done_r <= 1'b1;
          last_done_r <= s1_r.frame_id;
        end else begin
          pact_r      <= start || pact_e;
          have_done_r <= have_done_e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_addr_r <= idx;
    end
  end

  // Clearing pass after reset and on tag wrap.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      pass_cnt_r <= '0;
      keep_v_r   <= 1'b0;
    end else if (busy_r) begin
      pass_cnt_r <= pass_cnt_r + IDX_W'(1);
      if (pass_cnt_r == LAST_ADDR) begin
        busy_r     <= 1'b0;
        pass_cnt_r <= '0;
      end
    end else if (s1_fire && wrap) begin
      busy_r   <= 1'b1;
      keep_v_r <= store;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && wrap) begin
      keep_addr_r <= idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r[2:0]     <= verdict;
      out_data_r[34:3]    <= store ? s1_r.offset : '0;
      out_data_r[50:35]   <= store ? s1_r.frag_bytes : '0;
      out_data_r[51]      <= ok && res_chg;
      out_data_r[52]      <= ok && start;
      out_data_r[84:53]   <= complete ? size_e : '0;
      out_data_r[116:85]  <= ok ? drop_nxt : drop_r;
      out_data_r[148:117] <= ok ? done_nxt : done_r;
      out_data_r[149]     <= (cur_w_nxt != '0) && (cur_h_nxt != '0);
      out_data_r[151:150] <= '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Checks.
  a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_tready && !s1_v_r)
    else $error("header accepted or pending during bitmap clearing pass");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("bitmap generation reached the never-seen tag");

  a_count_below_total: assert property (@(posedge clk) disable iff (!rst_n)
    pact_r |-> (cnt_r < ptot_r) && (ptot_r != '0))
    else $error("pending frame fragment count out of range");

  a_complete_size: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && complete |=> out_tvalid && out_tdata[84:53] != 32'd0 &&
      out_tdata[116:85] == $past(drop_nxt))
    else $error("completed frame reported with zero size or bad drop count");

endmodule

`default_nettype wire

FILE: dv/frame_fragment_reassembly_tb.sv
`timescale 1ns / 1ps

module frame_fragment_reassembly_tb;
  import ffr_pkg::*;

  localparam int unsigned FRAG_SLOTS = 1024;
  localparam int unsigned PHASES = 6;

  // One fragment header as it travels on in_tdata, most significant field first.
  typedef struct packed {
    logic [31:0] pixel_height;
    logic [31:0] pixel_width;
    logic [31:0] frag_bytes;
    logic [31:0] frame_bytes;
    logic [31:0] frag_total;
    logic [31:0] frag_index;
    logic [31:0] frame_id;
    logic [31:0] magic_word;
    logic [15:0] packet_length;
  } frag_hdr_t;

  // One verdict beat as it travels on out_tdata, most significant field first.
  typedef struct packed {
    logic [1:0]  spare;
    logic        stream_seen;
    logic [31:0] completed_total;
    logic [31:0] dropped_total;
    logic [31:0] completed_size;
    logic        frame_started;
    logic        resolution_changed;
    logic [15:0] write_length;
    logic [31:0] write_offset;
    verdict_t    verdict;
  } verdict_beat_t;

  typedef struct packed {
    frag_hdr_t hdr;
    logic      pinned;
    verdict_t  want;
  } probe_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Verdict typed into the directed rows; it travels along with the header.
  logic pin_valid = 1'b0;
  verdict_t pin_verdict = V_STORED;

  frame_fragment_reassembly #(
    .MAX_FRAGMENTS(FRAG_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor copy of the registers and the reassembly state.
  logic [31:0]           m_magic;
  logic [15:0]           m_stride;
  logic [7:0]            m_hdr;
  logic [DIM_W-1:0]      m_wlim;
  logic [DIM_W-1:0]      m_hlim;
  logic                  asm_active;
  logic [31:0]           asm_id;
  logic [31:0]           asm_size;
  logic [10:0]           asm_total;
  logic [10:0]           asm_count;
  logic [FRAG_SLOTS-1:0] asm_seen;
  logic [31:0]           done_id;
  logic                  done_valid;
  logic [DIM_W-1:0]      res_w;
  logic [DIM_W-1:0]      res_h;
  logic [31:0]           drop_cnt;
  logic [31:0]           done_cnt;

  // Side outputs of one judgement.
  logic        fx_res_changed;
  logic        fx_started;
  logic [31:0] fx_offset;
  logic [15:0] fx_length;
  logic [31:0] fx_done_size;

  verdict_beat_t verdict_q[$];
  verdict_beat_t want_beat;
  verdict_beat_t got_beat;
  int unsigned fail_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned verdict_hits[7];

  // Stimulus side: the settings in force and the stream being generated.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic [31:0] run_magic;
  int unsigned run_stride;
  int unsigned run_hdr;
  int unsigned run_wlim;
  int unsigned run_hlim;
  int unsigned gen_w;
  int unsigned gen_h;
  int unsigned next_fid;
  probe_row_t probe_rows[25];

  initial begin
    #(5_000_000);
    $display("[frame_fragment_reassembly] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void clear_frame();
    asm_active = 1'b0;
    asm_id = '0;
    asm_size = '0;
    asm_total = '0;
    asm_count = '0;
    asm_seen = '0;
  endfunction

  function automatic void reset_model();
    m_magic = MAGIC_RST;
    m_stride = STRIDE_RST;
    m_hdr = HDR_BYTES_RST;
    m_wlim = WIDTH_LIM_RST;
    m_hlim = HEIGHT_LIM_RST;
    clear_frame();
    done_id = '0;
    done_valid = 1'b0;
    res_w = '0;
    res_h = '0;
    drop_cnt = '0;
    done_cnt = '0;
  endfunction

  function automatic verdict_t judge_fragment(input frag_hdr_t h);
    logic [63:0] place;
    logic [9:0]  slot;
    if (h.packet_length < m_hdr) return V_INVALID;
    if (h.magic_word != m_magic) return V_INVALID;
    if (h.frag_total == 0 || h.frag_index >= h.frag_total) return V_INVALID;
    if (h.frame_bytes == 0 || h.frag_bytes == 0) return V_INVALID;
    if (h.frag_bytes > 32'(m_stride)) return V_INVALID;
    if (h.pixel_width == 0 || h.pixel_height == 0) return V_INVALID;
    if (h.pixel_width > 32'(m_wlim) || h.pixel_height > 32'(m_hlim)) return V_INVALID;
    if (64'(h.packet_length) != 64'(m_hdr) + 64'(h.frag_bytes)) return V_INVALID;
    if (h.frag_total > FRAG_SLOTS) return V_TOO_MANY;

    // A new resolution throws away the pending frame and the completion history.
    if (h.pixel_width != 32'(res_w) || h.pixel_height != 32'(res_h)) begin
      res_w = h.pixel_width[DIM_W-1:0];
      res_h = h.pixel_height[DIM_W-1:0];
      clear_frame();
      done_valid = 1'b0;
      fx_res_changed = 1'b1;
    end

    if (done_valid && h.frame_id <= done_id) return V_STALE;
    if (asm_active && h.frame_id < asm_id) return V_STALE;

    if (!asm_active || h.frame_id != asm_id) begin
      if (asm_active && asm_count < asm_total) drop_cnt++;
      clear_frame();
      asm_active = 1'b1;
      asm_id = h.frame_id;
      asm_size = h.frame_bytes;
      asm_total = h.frag_total[10:0];
      fx_started = 1'b1;
    end

    slot = h.frag_index[9:0];
    if (asm_seen[slot]) return V_DUPLICATE;

    place = 64'(h.frag_index) * 64'(m_stride);
    if (place + 64'(h.frag_bytes) > 64'(asm_size)) return V_OFFSET;

    asm_seen[slot] = 1'b1;
    asm_count++;
    fx_offset = place[31:0];
    fx_length = h.frag_bytes[15:0];
    if (asm_count < asm_total) return V_STORED;

    done_id = asm_id;
    done_valid = 1'b1;
    done_cnt++;
    asm_active = 1'b0;
    fx_done_size = asm_size;
    return V_COMPLETE;
  endfunction

  function automatic verdict_beat_t predict_beat(input frag_hdr_t h);
    verdict_beat_t b;
    fx_res_changed = 1'b0;
    fx_started = 1'b0;
    fx_offset = '0;
    fx_length = '0;
    fx_done_size = '0;
    b.verdict = judge_fragment(h);
    b.spare = '0;
    b.write_offset = fx_offset;
    b.write_length = fx_length;
    b.resolution_changed = fx_res_changed;
    b.frame_started = fx_started;
    b.completed_size = fx_done_size;
    b.dropped_total = drop_cnt;
    b.completed_total = done_cnt;
    b.stream_seen = (res_w != 0) && (res_h != 0);
    return b;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC:      m_magic = cfg_wdata;
          CFG_STRIDE:     m_stride = cfg_wdata[15:0];
          CFG_HDR_BYTES:  m_hdr = cfg_wdata[7:0];
          CFG_WIDTH_LIM:  m_wlim = cfg_wdata[DIM_W-1:0];
          CFG_HEIGHT_LIM: m_hlim = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict beat arrived with no header outstanding");
          fail_cnt++;
        end else begin
          want_beat = verdict_q.pop_front();
          got_beat = out_tdata;
          if (got_beat.verdict <= V_TOO_MANY) verdict_hits[got_beat.verdict]++;
          check_field("verdict", 32'(want_beat.verdict), 32'(got_beat.verdict));
          check_field("write_offset", want_beat.write_offset, got_beat.write_offset);
          check_field("write_length", 32'(want_beat.write_length),
                      32'(got_beat.write_length));
          check_field("resolution_changed", 32'(want_beat.resolution_changed),
                      32'(got_beat.resolution_changed));
          check_field("frame_started", 32'(want_beat.frame_started),
                      32'(got_beat.frame_started));
          check_field("completed_size", want_beat.completed_size,
                      got_beat.completed_size);
          check_field("dropped_total", want_beat.dropped_total, got_beat.dropped_total);
          check_field("completed_total", want_beat.completed_total,
                      got_beat.completed_total);
          check_field("stream_seen", 32'(want_beat.stream_seen),
                      32'(got_beat.stream_seen));
        end
      end
      if (in_tvalid && in_tready) begin
        want_beat = predict_beat(frag_hdr_t'(in_tdata));
        if (pin_valid) want_beat.verdict = pin_verdict;
        verdict_q.push_back(want_beat);
      end
    end
  end

  task automatic push_hdr(input frag_hdr_t h, input logic pinned, input verdict_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata <= h;
    in_tvalid <= 1'b1;
    pin_valid <= pinned;
    pin_verdict <= want;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_idle(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 59; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 59; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic write_registers(input logic [31:0] magic, input int unsigned stride,
                                 input int unsigned hdr, input int unsigned wlim,
                                 input int unsigned hlim);
    run_magic = magic;
    run_stride = stride;
    run_hdr = hdr;
    run_wlim = wlim;
    run_hlim = hlim;
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= CFG_STRIDE;
    cfg_wdata <= 32'(stride);
    @(posedge clk);
    cfg_index <= CFG_HDR_BYTES;
    cfg_wdata <= 32'(hdr);
    @(posedge clk);
    cfg_index <= CFG_WIDTH_LIM;
    cfg_wdata <= 32'(wlim);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT_LIM;
    cfg_wdata <= 32'(hlim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned p);
    case (p)
      0: write_registers(32'hA5C3_0F1E, 1400, 36, 7680, 4320);
      1: write_registers(32'hFFFF_FFFF, 1, 1, 1, 1);
      2: write_registers(32'h0000_0000, 65507, 255, 8191, 8191);
      3: write_registers($urandom, $urandom_range(64, 9000), $urandom_range(8, 80),
                         $urandom_range(16, 8191), $urandom_range(16, 8191));
      4: write_registers($urandom, 512, 28, 1920, 1080);
      default: write_registers($urandom, $urandom_range(1, 200), $urandom_range(1, 255),
                               $urandom_range(1, 64), $urandom_range(1, 64));
    endcase
  endtask

  task automatic pick_resolution();
    int unsigned w;
    int unsigned hgt;
    do begin
      w = $urandom_range(1, run_wlim);
      hgt = $urandom_range(1, run_hlim);
    end while (w == gen_w && hgt == gen_h && (run_wlim > 1 || run_hlim > 1));
    gen_w = w;
    gen_h = hgt;
  endtask

  function automatic frag_hdr_t mk_hdr(input logic [15:0] plen, input logic [31:0] magic,
                                       input logic [31:0] fid, input logic [31:0] idx,
                                       input logic [31:0] tot, input logic [31:0] fbytes,
                                       input logic [31:0] gbytes, input logic [31:0] w,
                                       input logic [31:0] hgt);
    frag_hdr_t h;
    h.packet_length = plen;
    h.magic_word = magic;
    h.frame_id = fid;
    h.frag_index = idx;
    h.frag_total = tot;
    h.frame_bytes = fbytes;
    h.frag_bytes = gbytes;
    h.pixel_width = w;
    h.pixel_height = hgt;
    return h;
  endfunction

  task automatic send_fragment(input logic [31:0] fid, input int unsigned idx,
                               input int unsigned total, input logic [31:0] fsize,
                               input int unsigned cap, input int unsigned last_len);
    frag_hdr_t h;
    int unsigned glen;
    logic [IN_DATA_W-1:0] flip;
    glen = (idx == total - 1) ? last_len : cap;
    h = mk_hdr(16'(run_hdr + glen), run_magic, fid, idx, total, fsize, glen,
               gen_w, gen_h);
    // Any fragment may disagree about the fragment count.
    if ($urandom_range(14) == 0) h.frag_total = $urandom_range(1, total + 3);
    if ($urandom_range(24) == 0) begin
      flip = '0;
      flip[$urandom_range(IN_DATA_W - 1)] = 1'b1;
      h = h ^ flip;
    end
    push_hdr(h, 1'b0, V_STORED);
  endtask

  task automatic send_frame();
    int unsigned total;
    int unsigned cap;
    int unsigned last_len;
    int unsigned j;
    int unsigned k;
    int unsigned tmp;
    logic [31:0] fid;
    logic [31:0] fsize;
    int unsigned order[$];
    frag_hdr_t h;
    if ($urandom_range(19) == 0) begin
      h = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, 16'($urandom)};
      if ($urandom_range(1) == 0) h.magic_word = run_magic;
      push_hdr(h, 1'b0, V_STORED);
      return;
    end
    if ($urandom_range(11) == 0) pick_resolution();
    // Now and then hold the sender until the block has answered everything.
    if ($urandom_range(39) == 0) wait_for_results();
    cap = (run_hdr + run_stride > 65535) ? 65535 - run_hdr : run_stride;
    case ($urandom_range(49))
      0:             total = $urandom_range(FRAG_SLOTS + 1, 4096);
      1, 2:          total = $urandom_range(41, FRAG_SLOTS);
      3, 4, 5, 6, 7: total = $urandom_range(7, 40);
      default:       total = $urandom_range(1, 6);
    endcase
    if ($urandom_range(9) == 0 && next_fid > 4) begin
      fid = next_fid - $urandom_range(1, 4);
    end else begin
      next_fid += $urandom_range(1, 3);
      fid = next_fid;
    end
    last_len = $urandom_range(1, cap);
    fsize = (total - 1) * run_stride + last_len;
    if ($urandom_range(9) == 0) fsize = $urandom_range(1, fsize);
    if (total > 40) begin
      // Large frames only get a handful of fragments and end up dropped.
      for (k = 0; k < 6; k++) order.push_back((k == 0) ? total - 1 : $urandom_range(total - 1));
    end else begin
      for (k = 0; k < total; k++) order.push_back(k);
      for (k = total - 1; k > 0; k--) begin
        j = $urandom_range(k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      if (total > 1 && $urandom_range(7) == 0) void'(order.pop_back());
    end
    for (k = 0; k < order.size(); k++) begin
      send_fragment(fid, order[k], total, fsize, cap, last_len);
      if ($urandom_range(11) == 0)
        send_fragment(fid, order[$urandom_range(k)], total, fsize, cap, last_len);
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned r;
    int unsigned mark;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // Reset settings: magic 0, stride 1400, 36 header bytes, 7680 x 4320 limits.
    probe_rows[0]  = '{mk_hdr(0, 0, 1, 0, 1, 100, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[1]  = '{mk_hdr(136, '1, 1, 0, 1, 100, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[2]  = '{mk_hdr(136, 0, 1, 0, 0, 100, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[3]  = '{mk_hdr(136, 0, 1, 2, 2, 100, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[4]  = '{mk_hdr(136, 0, 1, 0, 1, 0, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[5]  = '{mk_hdr(36, 0, 1, 0, 1, 100, 0, 640, 480), 1'b1, V_INVALID};
    probe_rows[6]  = '{mk_hdr(1437, 0, 1, 0, 1, 2000, 1401, 640, 480), 1'b1, V_INVALID};
    probe_rows[7]  = '{mk_hdr(136, 0, 1, 0, 1, 100, 100, 0, 480), 1'b1, V_INVALID};
    probe_rows[8]  = '{mk_hdr(136, 0, 1, 0, 1, 100, 100, 640, 0), 1'b1, V_INVALID};
    probe_rows[9]  = '{mk_hdr(136, 0, 1, 0, 1, 100, 100, 7681, 480), 1'b1, V_INVALID};
    probe_rows[10] = '{mk_hdr(136, 0, 1, 0, 1, 100, 100, 640, 4321), 1'b1, V_INVALID};
    probe_rows[11] = '{mk_hdr(137, 0, 1, 0, 1, 100, 100, 640, 480), 1'b1, V_INVALID};
    probe_rows[12] = '{mk_hdr('1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, V_INVALID};
    probe_rows[13] = '{mk_hdr(136, 0, 1, 0, 1025, 2000, 100, 640, 480), 1'b1, V_TOO_MANY};
    probe_rows[14] = '{mk_hdr(1436, 0, 10, 1, 3, 3000, 1400, 640, 480), 1'b0, V_STORED};
    probe_rows[15] = '{mk_hdr(1436, 0, 10, 1, 3, 3000, 1400, 640, 480), 1'b1, V_DUPLICATE};
    probe_rows[16] = '{mk_hdr(1436, 0, 10, 2, 3, 3000, 1400, 640, 480), 1'b1, V_OFFSET};
    probe_rows[17] = '{mk_hdr(1436, 0, 10, 0, 5, 3000, 1400, 640, 480), 1'b0, V_STORED};
    probe_rows[18] = '{mk_hdr(236, 0, 10, 2, 3, 3000, 200, 640, 480), 1'b0, V_STORED};
    probe_rows[19] = '{mk_hdr(1436, 0, 10, 0, 3, 3000, 1400, 640, 480), 1'b1, V_STALE};
    probe_rows[20] = '{mk_hdr(1436, 0, 12, 0, 2, 2800, 1400, 640, 480), 1'b0, V_STORED};
    probe_rows[21] = '{mk_hdr(1436, 0, 11, 0, 2, 2800, 1400, 640, 480), 1'b1, V_STALE};
    probe_rows[22] = '{mk_hdr(136, 0, 13, 0, 1, 100, 100, 640, 480), 1'b0, V_STORED};
    probe_rows[23] = '{mk_hdr(1436, 0, 0, 1023, 1024, '1, 1400, 7680, 4320), 1'b0, V_STORED};
    probe_rows[24] = '{mk_hdr(37, 0, '1, 0, 1, 1, 1, 7680, 4320), 1'b0, V_STORED};
    for (r = 0; r < 25; r++) push_hdr(probe_rows[r].hdr, probe_rows[r].pinned, probe_rows[r].want);
    wait_for_results();

    gen_w = 7680;
    gen_h = 4320;
    for (p = 0; p < PHASES; p++) begin
      apply_setting(p);
      pick_resolution();
      next_fid = $urandom_range(0, 1000);
      mark = sent_cnt;
      set_idle(p % 4);
      while (sent_cnt < mark + 150) send_frame();
      set_idle((p + 1) % 4);
      while (sent_cnt < mark + 300) send_frame();
      wait_for_results();
    end

    $display("%0d fragment headers over %0d register settings: %0d stored, %0d complete,",
             sent_cnt, PHASES + 1, verdict_hits[V_STORED], verdict_hits[V_COMPLETE]);
    $display("%0d invalid, %0d stale, %0d duplicate, %0d bad offset, %0d over the bitmap.",
             verdict_hits[V_INVALID], verdict_hits[V_STALE], verdict_hits[V_DUPLICATE],
             verdict_hits[V_OFFSET], verdict_hits[V_TOO_MANY]);
    if (fail_cnt == 0) begin
      $display("[frame_fragment_reassembly] OK");
    end else begin
      $display("[frame_fragment_reassembly] ERROR");
    end
    $finish;
  end

endmodule
